// ===== hdl/olsd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// olsd_pkg
// shared constants, codes and reset values of the open-loop startup drive
// ----------------------------------------------------------------------------
package olsd_pkg;

	// default build-time sizes
	localparam int TABLE_SIZE_DEF = 1024;
	localparam int SINE_BITS_DEF  = 16;

	// pi/2 in Q30, used by the sine table build
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// throttle limits, Q1.16
	localparam logic [16:0] THR_FULL = 17'd65536;
	localparam logic [16:0] THR_STOP = 17'd655;

	localparam logic [20:0] RAMP_CNT_MAX = 21'h1FFFFF;

	// drive modes
	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_ALIGN = 2'd1;
	localparam logic [1:0] MODE_RAMP  = 2'd2;
	localparam logic [1:0] MODE_RUN   = 2'd3;

	// item kinds
	localparam logic [1:0] ACT_TICK     = 2'd0;
	localparam logic [1:0] ACT_THROTTLE = 2'd1;
	localparam logic [1:0] ACT_RELEASE  = 2'd2;

	// register indexes
	localparam logic [2:0] REG_ALIGN_LEN   = 3'd0;
	localparam logic [2:0] REG_RAMP_MIN    = 3'd1;
	localparam logic [2:0] REG_AMPLITUDE   = 3'd2;
	localparam logic [2:0] REG_BASE_SPEED  = 3'd3;
	localparam logic [2:0] REG_THR_GAIN    = 3'd4;
	localparam logic [2:0] REG_SMOOTH      = 3'd5;
	localparam logic [2:0] REG_RAMP_START  = 3'd6;
	localparam logic [2:0] REG_RAMP_STEP   = 3'd7;

	// register reset values
	localparam logic [19:0] RST_ALIGN_LEN   = 20'd20000;
	localparam logic [19:0] RST_RAMP_MIN    = 20'd4000;
	localparam logic [14:0] RST_AMPLITUDE   = 15'd645;
	localparam logic [31:0] RST_BASE_SPEED  = 32'd21474836;
	localparam logic [31:0] RST_THR_GAIN    = 32'd644245094;
	localparam logic [31:0] RST_SMOOTH      = 32'd858993;
	localparam logic [31:0] RST_RAMP_START  = 32'd8589935;
	localparam logic [31:0] RST_RAMP_STEP   = 32'd1288;

endpackage
`default_nettype wire

// ===== hdl/olsd_sine_rom.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// olsd_sine_rom
// three-column sine table (0, 120, 240 degrees), stored as offset level
// 2^F + sine, built at elaboration, registered read
// ----------------------------------------------------------------------------
module olsd_sine_rom
	import olsd_pkg::*;
#(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF,
	parameter int SINE_BITS  = SINE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          rd_en,
	input  wire logic [$clog2(TABLE_SIZE)-1:0] idx,
	output logic      [SINE_BITS-1:0]          level_u,
	output logic      [SINE_BITS-1:0]          level_v,
	output logic      [SINE_BITS-1:0]          level_w
);

	localparam longint unsigned DEN  = 64'(3 * TABLE_SIZE);
	localparam int              FRAC = SINE_BITS - 1;
	localparam longint unsigned ONE  = 64'd1 << FRAC;
	localparam longint unsigned LIM  = ONE - 64'd1;

	logic [SINE_BITS-1:0] lvl_tbl [TABLE_SIZE][3];

	for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_row
		for (genvar m = 0; m < 3; m++) begin : g_col
			localparam longint unsigned P  = (64'(3 * k) + 64'(m * TABLE_SIZE)) % DEN;
			localparam longint unsigned U  = 64'd4 * P;
			localparam longint unsigned QD = U / DEN;
			localparam longint unsigned R0 = U % DEN;
			localparam longint unsigned R  = ((QD % 2) == 1) ? (DEN - R0) : R0;
			localparam longint unsigned X  = (R * HALF_PI_Q30) / DEN;
			localparam longint unsigned T1 = ((((X * X) >> 30) * X) >> 30) / 6;
			localparam longint unsigned T2 = ((((T1 * X) >> 30) * X) >> 30) / 20;
			localparam longint unsigned T3 = ((((T2 * X) >> 30) * X) >> 30) / 42;
			localparam longint unsigned T4 = ((((T3 * X) >> 30) * X) >> 30) / 72;
			localparam longint unsigned T5 = ((((T4 * X) >> 30) * X) >> 30) / 110;
			localparam longint unsigned T6 = ((((T5 * X) >> 30) * X) >> 30) / 156;
			localparam longint SUM = longint'(X) - longint'(T1) + longint'(T2)
				- longint'(T3) + longint'(T4) - longint'(T5) + longint'(T6);
			localparam longint unsigned SC = (SUM < 0) ? 64'd0 : longint'(SUM);
			localparam longint unsigned S0 = ((SC << FRAC) + (64'd1 << 29)) >> 30;
			localparam longint unsigned S  = (S0 > LIM) ? LIM : S0;
			localparam longint unsigned LV = (QD >= 2) ? (ONE - S) : (ONE + S);
			assign lvl_tbl[k][m] = SINE_BITS'(LV);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			level_u <= lvl_tbl[idx][0];
			level_v <= lvl_tbl[idx][1];
			level_w <= lvl_tbl[idx][2];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/open_loop_motor_startup_drive_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// open_loop_motor_startup_drive_top
// open-loop three-phase startup sequencer: idle, align, ramp, run
// ----------------------------------------------------------------------------
// Each input transaction is a commutation tick, a throttle command or a
// release, and yields exactly one output transaction carrying the mode after
// the item and, for active ticks, three phase duties
// amplitude*(2^F+sine)>>F. The whole drive state (mode, throttle, Q.32 phase
// accumulator, ramp and run speed, align and ramp counts) sits in a
// single-entry state memory with a registered read; an item reads it,
// walks a fixed sequence (state read, throttle*gain multiply, target and
// difference, smoothing multiply, speed update, phase update and write-back,
// sine table read, duty multiply) and writes it back before the next item is
// taken, and each item holds the block in its duty step for as long as the
// output register is full and waits for m_tready. A result may sit in the
// output register while the next item is already being worked on. The state
// memory entry carries one valid flop cleared by reset, so no clearing pass
// is needed. Configuration goes through the APB port, register i at byte
// address 4*i; write it only while the block is idle.
// ----------------------------------------------------------------------------
module open_loop_motor_startup_drive_top
	import olsd_pkg::*;
#(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF,
	parameter int SINE_BITS  = SINE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// apb configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [16:0] throttle_in, zero fill above
	input  wire logic [1:0]  s_tuser,   // [1:0] action
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [47:0] m_tdata,   // [15:0] duty_u, [31:16] duty_v, [47:32] duty_w
	output logic      [2:0]  m_tuser    // [1:0] mode, [2] duty_valid
);

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int PH_W  = IDX_W + 32;
	localparam int FRAC  = SINE_BITS - 1;
	// phase wraps at TABLE_SIZE table entries
	localparam logic [PH_W:0] PH_LIM = {(IDX_W + 1)'(TABLE_SIZE), 32'd0};

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD   = 4'd1;
	localparam logic [3:0] ST_M1   = 4'd2;
	localparam logic [3:0] ST_M2   = 4'd3;
	localparam logic [3:0] ST_M3   = 4'd4;
	localparam logic [3:0] ST_SPD  = 4'd5;
	localparam logic [3:0] ST_UPD  = 4'd6;
	localparam logic [3:0] ST_ROM  = 4'd7;
	localparam logic [3:0] ST_DUTY = 4'd8;

	typedef struct packed {
		logic [1:0]      mode;
		logic [16:0]     thl;
		logic [PH_W-1:0] ph;
		logic [31:0]     rs;
		logic [31:0]     rns;
		logic [19:0]     ac;
		logic [20:0]     rc;
	} drv_state_t;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [19:0] align_len_q;
	logic [19:0] ramp_min_q;
	logic [14:0] amp_q;
	logic [31:0] base_q;
	logic [31:0] gain_q;
	logic [31:0] smooth_q;
	logic [31:0] ramp_start_q;
	logic [31:0] ramp_step_q;

	logic        cfg_wr;
	logic [2:0]  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_len_q   <= RST_ALIGN_LEN;
			ramp_min_q    <= RST_RAMP_MIN;
			amp_q         <= RST_AMPLITUDE;
			base_q        <= RST_BASE_SPEED;
			gain_q        <= RST_THR_GAIN;
			smooth_q      <= RST_SMOOTH;
			ramp_start_q  <= RST_RAMP_START;
			ramp_step_q   <= RST_RAMP_STEP;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_ALIGN_LEN:   align_len_q   <= pwdata[19:0];
				REG_RAMP_MIN:    ramp_min_q    <= pwdata[19:0];
				REG_AMPLITUDE:   amp_q         <= pwdata[14:0];
				REG_BASE_SPEED:  base_q        <= pwdata;
				REG_THR_GAIN:    gain_q        <= pwdata;
				REG_SMOOTH:      smooth_q      <= pwdata;
				REG_RAMP_START:  ramp_start_q  <= pwdata;
				REG_RAMP_STEP:   ramp_step_q   <= pwdata;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (cfg_idx)
			REG_ALIGN_LEN:   prdata = {12'd0, align_len_q};
			REG_RAMP_MIN:    prdata = {12'd0, ramp_min_q};
			REG_AMPLITUDE:   prdata = {17'd0, amp_q};
			REG_BASE_SPEED:  prdata = base_q;
			REG_THR_GAIN:    prdata = gain_q;
			REG_SMOOTH:      prdata = smooth_q;
			REG_RAMP_START:  prdata = ramp_start_q;
			REG_RAMP_STEP:   prdata = ramp_step_q;
		endcase
	end

	// ------------------------------------------------------------------
	// sequencer and item capture
	// ------------------------------------------------------------------
	logic [3:0]  st_q;
	logic [1:0]  act_q;
	logic [16:0] thr_q;
	logic        out_free;
	logic        s_acc;
	logic [16:0] thr_clamp;

	assign s_tready  = (st_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	// result register can take a new transaction this cycle
	assign out_free  = !m_tvalid || m_tready;
	assign thr_clamp = (s_tdata[16:0] > THR_FULL) ? THR_FULL : s_tdata[16:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			unique case (st_q)
				ST_IDLE: if (s_acc) st_q <= ST_RD;
				ST_RD:   st_q <= ST_M1;
				ST_M1:   st_q <= ST_M2;
				ST_M2:   st_q <= ST_M3;
				ST_M3:   st_q <= ST_SPD;
				ST_SPD:  st_q <= ST_UPD;
				ST_UPD:  st_q <= ST_ROM;
				ST_ROM:  st_q <= ST_DUTY;
				ST_DUTY: if (out_free) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			act_q <= s_tuser;
			thr_q <= thr_clamp;
		end
	end

	// ------------------------------------------------------------------
	// state memory: single entry, read in ST_RD, written back in ST_UPD;
	// the next item is only taken after write-back, so reads never overlap
	// ------------------------------------------------------------------
	drv_state_t state_mem [1];
	drv_state_t rd_q;
	drv_state_t cur;
	drv_state_t nx;
	logic       st_vld_q;

	always_ff @(posedge clk) begin
		if (st_q == ST_UPD) state_mem[0] <= nx;
		if (st_q == ST_RD)  rd_q <= state_mem[0];
	end

	// entry never written reads as the all-zero reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_vld_q <= 1'b0;
		else if (st_q == ST_UPD) st_vld_q <= 1'b1;
	end

	assign cur = st_vld_q ? rd_q : '0;

	// ------------------------------------------------------------------
	// run speed chain
	// ------------------------------------------------------------------
	logic [48:0] tprod_s1;
	logic [31:0] diff_s2;
	logic        up_s2;
	logic [31:0] dq_s3;
	logic [31:0] rns_s4;
	logic [31:0] rs_s4;
	logic [33:0] tgt_sum;
	logic [31:0] tgt;
	logic [63:0] dprod;
	logic [32:0] ns_sum;

	// target = base + throttle*gain>>16, saturated to 32 bits
	assign tgt_sum = 34'(base_q) + 34'(tprod_s1[48:16]);
	assign tgt     = (tgt_sum[33:32] != 2'd0) ? 32'hFFFF_FFFF : tgt_sum[31:0];
	assign dprod   = diff_s2 * smooth_q;
	// ramp speed step, clipped at base speed
	assign ns_sum  = {1'b0, cur.rs} + {1'b0, ramp_step_q};

	always_ff @(posedge clk) begin
		if (st_q == ST_M1) tprod_s1 <= cur.thl * gain_q;
		if (st_q == ST_M2) begin
			up_s2   <= (tgt >= cur.rns);
			diff_s2 <= (tgt >= cur.rns) ? (tgt - cur.rns) : (cur.rns - tgt);
		end
		if (st_q == ST_M3) dq_s3 <= dprod[63:32];
		if (st_q == ST_SPD) begin
			rns_s4 <= up_s2 ? (cur.rns + dq_s3) : (cur.rns - dq_s3);
			rs_s4  <= (ns_sum > {1'b0, base_q}) ? base_q : ns_sum[31:0];
		end
	end

	// ------------------------------------------------------------------
	// next state
	// ------------------------------------------------------------------
	logic [31:0]    adv_speed;
	logic [PH_W:0]  ph_sum;
	logic [PH_W:0]  ph_wrap;
	logic [PH_W-1:0] ph_new;
	logic [19:0]    ac_new;
	logic [20:0]    rc_new;
	logic           emit;
	logic [IDX_W-1:0] idx;

	assign adv_speed = (cur.mode == MODE_RUN) ? rns_s4 : cur.rs;
	assign ph_sum    = {1'b0, cur.ph} + (PH_W + 1)'(adv_speed);
	assign ph_wrap   = (ph_sum >= PH_LIM) ? (ph_sum - PH_LIM) : ph_sum;
	assign ph_new    = ph_wrap[PH_W-1:0];
	assign ac_new    = cur.ac + 20'd1;
	assign rc_new    = (cur.rc == RAMP_CNT_MAX) ? cur.rc : (cur.rc + 21'd1);

	always_comb begin
		nx   = cur;
		emit = 1'b0;
		idx  = '0;
		unique case (act_q)
			ACT_THROTTLE: begin
				nx.thl = thr_q;
				if ((thr_q < THR_STOP) && (cur.mode != MODE_IDLE)) begin
					nx.mode = MODE_IDLE;
					nx.ph   = '0;
					nx.rs   = '0;
					nx.rns  = '0;
				end else if ((thr_q > THR_STOP) && (cur.mode == MODE_IDLE)) begin
					nx.mode = MODE_ALIGN;
					nx.ac   = '0;
					nx.rc   = '0;
					nx.ph   = '0;
					nx.rs   = ramp_start_q;
					nx.rns  = base_q;
				end
			end
			ACT_RELEASE: begin
				nx.mode = MODE_IDLE;
				nx.thl  = '0;
				nx.ph   = '0;
				nx.rs   = '0;
				nx.rns  = '0;
			end
			ACT_TICK: begin
				unique case (cur.mode)
					MODE_ALIGN: begin
						emit  = 1'b1;
						nx.ac = ac_new;
						if (ac_new >= align_len_q) begin
							nx.mode = MODE_RAMP;
							nx.rc   = '0;
						end
					end
					MODE_RAMP: begin
						emit  = 1'b1;
						nx.ph = ph_new;
						nx.rs = rs_s4;
						nx.rc = rc_new;
						idx   = ph_new[PH_W-1:32];
						if ((rc_new > {1'b0, ramp_min_q}) && (rs_s4 >= base_q))
							nx.mode = MODE_RUN;
					end
					MODE_RUN: begin
						emit   = 1'b1;
						nx.rns = rns_s4;
						nx.ph  = ph_new;
						idx    = ph_new[PH_W-1:32];
					end
					MODE_IDLE: ;
				endcase
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// sine table and duty multiply
	// ------------------------------------------------------------------
	logic [IDX_W-1:0]     idx_q;
	logic                 emit_q;
	logic [1:0]           mode_q;
	logic [SINE_BITS-1:0] lvl_u;
	logic [SINE_BITS-1:0] lvl_v;
	logic [SINE_BITS-1:0] lvl_w;
	logic [FRAC+15:0]     pu;
	logic [FRAC+15:0]     pv;
	logic [FRAC+15:0]     pw;

	always_ff @(posedge clk) begin
		if (st_q == ST_UPD) begin
			idx_q  <= idx;
			emit_q <= emit;
			mode_q <= nx.mode;
		end
	end

	olsd_sine_rom #(
		.TABLE_SIZE (TABLE_SIZE),
		.SINE_BITS  (SINE_BITS)
	) u_rom (
		.clk     (clk),
		.rd_en   (st_q == ST_ROM),
		.idx     (idx_q),
		.level_u (lvl_u),
		.level_v (lvl_v),
		.level_w (lvl_w)
	);

	assign pu = amp_q * lvl_u;
	assign pv = amp_q * lvl_v;
	assign pw = amp_q * lvl_w;

	// output register; the next item may run while this waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if ((st_q == ST_DUTY) && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((st_q == ST_DUTY) && out_free) begin
			m_tuser <= {emit_q, mode_q};
			m_tdata <= emit_q ? {pw[FRAC+15:FRAC], pv[FRAC+15:FRAC], pu[FRAC+15:FRAC]}
			                  : 48'd0;
		end
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_duty_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] != MODE_IDLE))
		else $error("duties flagged valid in idle mode");

	a_state_written: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_UPD) |=> st_vld_q)
		else $error("state entry not marked valid after write-back");

	a_phase_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_UPD) |-> ({1'b0, nx.ph} < PH_LIM))
		else $error("phase accumulator beyond wrap limit");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (st_q == ST_RD))
		else $error("accepted item did not start a state read");

endmodule
`default_nettype wire
